// ----- src/sth_pkg.sv -----
// sth_pkg: word types, action codes and arithmetic constants for the
// sample time-tag history block. No dependencies.
package sth_pkg;

	localparam int TB_W = 9;

	localparam logic [1:0] ACT_ALARM = 2'd0;
	localparam logic [1:0] ACT_TICK  = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	localparam logic [31:0] EPOCH_OFFSET   = 32'd2208988800;
	localparam logic [19:0] MICROS_PER_SEC = 20'd1000000;
	// floor(2^50 / 10^6) and floor(2^51 / 10^6)
	localparam logic [30:0] RECIP_WHOLE    = 31'd1125899906;
	localparam logic [31:0] RECIP_FRAC     = 32'd2251799813;

	typedef struct packed {
		logic [1:0]      action;
		logic [31:0]     micro_time;
		logic [31:0]     rtc_seconds;
		logic [TB_W-1:0] ticks_back;
	} in_word_t;

	typedef struct packed {
		logic        from_query;
		logic [31:0] tag_seconds;
		logic [31:0] tag_fraction;
		logic        date_latched;
	} out_word_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] diff;
		logic [31:0] base;
	} calc_req_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] seconds;
		logic [31:0] fraction;
	} calc_res_t;

endpackage

// ----- src/sth_hist_mem.sv -----
// sth_hist_mem: tag history RAM, one write port, one read port with
// registered read data. No dependencies.
module sth_hist_mem #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [63:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [63:0]   rdata
);

	logic [63:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/sth_back_mod.sv -----
// sth_back_mod: reduces the query distance modulo the history depth.
// Registered reciprocal quotient, then remainder, when the depth is neither a power of two nor >= 512.
// Depends on sth_pkg.
module sth_back_mod
	import sth_pkg::*;
#(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [TB_W-1:0] ticks_back,
	output logic            done,
	output logic [AW-1:0]   back
);

	localparam bit DIRECT = (DEPTH >= (1 << TB_W)) || ((DEPTH & (DEPTH - 1)) == 0);

	logic          done_q;
	logic [AW-1:0] back_q;

	generate
		if (DIRECT) begin : g_direct
			logic [TB_W-1:0] masked;
			if (DEPTH >= (1 << TB_W)) begin : g_wide
				assign masked = ticks_back;
			end else begin : g_pow2
				assign masked = ticks_back & TB_W'(DEPTH - 1);
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					back_q <= AW'(masked);
				end
			end
		end else begin : g_recip
			// ceil(2^(TB_W+AW) / DEPTH) gives an exact quotient for any TB_W-bit distance
			localparam int                 SH      = TB_W + AW;
			localparam int                 RECIP_W = TB_W + 2;
			localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(((1 << SH) + DEPTH - 1) / DEPTH);
			localparam logic [TB_W-1:0]    DEPTH_N = TB_W'(DEPTH);
			logic                     run_q;
			logic [TB_W-1:0]          num_q;
			logic [TB_W-1:0]          quo_q;
			logic [TB_W+RECIP_W-1:0]  prod;
			logic [TB_W-1:0]          rem;

			assign prod = (TB_W+RECIP_W)'(ticks_back) * (TB_W+RECIP_W)'(RECIP);
			assign rem  = num_q - quo_q * DEPTH_N;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					run_q  <= 1'b0;
					done_q <= 1'b0;
				end else begin
					run_q  <= start;
					done_q <= run_q;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					num_q <= ticks_back;
					quo_q <= TB_W'(prod >> SH);
				end
				if (run_q) begin
					back_q <= AW'(rem);
				end
			end
		end
	endgenerate

	assign done = done_q;
	assign back = back_q;

endmodule

// ----- src/sth_tag_calc.sv -----
// sth_tag_calc: six-stage pipeline turning a microsecond difference and a
// base second count into a 32.32 time tag. Depends on sth_pkg.
module sth_tag_calc
	import sth_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  calc_req_t req,
	output calc_res_t res
);

	localparam logic [22:0] RESID_ONE = 23'(MICROS_PER_SEC);
	localparam logic [22:0] RESID_TWO = 23'd2000000;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [31:0] diff_s1, diff_s2;
	logic [31:0] base_s1, base_s2, base_s3, base_s4;
	logic [12:0] q_s2, q_s3, whole_s4;
	logic [21:0] rraw_s3;
	logic [19:0] rem_s4;
	logic [31:0] f_s5, f_s6;
	logic [31:0] secs_s5, secs_s6;
	logic [22:0] resid_s6;

	logic [62:0] prod_whole;
	logic [21:0] qm;
	logic        ge_one;
	logic [51:0] prod_frac;
	logic [22:0] fm;

	assign prod_whole = 63'(diff_s1) * 63'(RECIP_WHOLE);
	assign qm         = 22'(q_s2) * 22'(MICROS_PER_SEC);
	assign ge_one     = rraw_s3 >= 22'(MICROS_PER_SEC);
	assign prod_frac  = 52'(rem_s4) * 52'(RECIP_FRAC);
	assign fm         = 23'(f_s5) * 23'(MICROS_PER_SEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		diff_s1  <= req.diff;
		base_s1  <= req.base;
		q_s2     <= prod_whole[62:50];
		diff_s2  <= diff_s1;
		base_s2  <= base_s1;
		rraw_s3  <= diff_s2[21:0] - qm;
		q_s3     <= q_s2;
		base_s3  <= base_s2;
		rem_s4   <= ge_one ? 20'(rraw_s3 - 22'(MICROS_PER_SEC)) : rraw_s3[19:0];
		whole_s4 <= q_s3 + 13'(ge_one);
		base_s4  <= base_s3;
		f_s5     <= prod_frac[50:19];
		secs_s5  <= base_s4 + 32'(whole_s4);
		resid_s6 <= 23'd0 - fm;
		f_s6     <= f_s5;
		secs_s6  <= secs_s5;
	end

	// reciprocal estimate runs up to two low; residual fixes it
	assign res.valid    = v_s6;
	assign res.seconds  = secs_s6;
	assign res.fraction = f_s6 + 32'(resid_s6 >= RESID_ONE) + 32'(resid_s6 >= RESID_TWO);

endmodule

// ----- src/sample_timestamp_history_top.sv -----
// sample_timestamp_history_top: sequencer, alarm/date registers and ring
// pointer around the tag pipeline, distance reducer and history RAM.
// Depends on sth_pkg, sth_tag_calc, sth_back_mod, sth_hist_mem.
//
//  word     | ports               | handshake
//  ---------+---------------------+------------------------------------
//  command  | item (in_word_t)    | taken when start && !busy
//  result   | result (out_word_t) | valid for the one cycle done is high
//
// Alarm: handled in the idle state. Tick: passes through the six-stage tag pipeline.
// Query: distance, RAM read, output register, with a reciprocal quotient register ahead
// of the distance remainder when the depth is below 512 and not a power of two.
// History reads as zero until written, tracked by the write pointer and a
// wrap flag; no clearing pass. Result words cannot be held off.
module sample_timestamp_history_top
	import sth_pkg::*;
#(
	parameter int HISTORY_DEPTH = 512
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_word_t  item,
	output logic      busy,
	output logic      done,
	output out_word_t result
);

	localparam int          AW      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam logic [AW:0] DEPTH_W = (AW+1)'(HISTORY_DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_TICK = 3'd1;
	localparam logic [2:0] ST_MOD  = 3'd2;
	localparam logic [2:0] ST_READ = 3'd3;

	logic [2:0]    state_q;
	logic          pending_q;
	logic [31:0]   ref_q;
	logic [31:0]   latched_q;
	logic [AW-1:0] slot_q;
	logic          wrapped_q;
	logic          date_q;
	logic          hit_q;
	logic          done_q;
	out_word_t     out_q;

	logic          accept;
	logic [31:0]   base;
	calc_req_t     calc_req;
	calc_res_t     calc_res;
	logic          mod_start;
	logic          mod_done;
	logic [AW-1:0] back;
	logic [AW:0]   sum;
	logic [AW-1:0] idx;
	logic          mem_we;
	logic          mem_re;
	logic [63:0]   rdata;

	assign accept = start && !busy;
	assign busy   = state_q != ST_IDLE;
	assign base   = pending_q ? item.rtc_seconds + EPOCH_OFFSET : latched_q;

	assign calc_req.valid = accept && item.action == ACT_TICK;
	assign calc_req.diff  = item.micro_time - ref_q;
	assign calc_req.base  = base;

	assign mod_start = accept && item.action == ACT_QUERY;

	assign sum = {1'b0, slot_q} + DEPTH_W - {1'b0, back} - (AW+1)'(1);
	assign idx = (sum >= DEPTH_W) ? AW'(sum - DEPTH_W) : AW'(sum);

	assign mem_we = state_q == ST_TICK && calc_res.valid;
	assign mem_re = state_q == ST_MOD && mod_done;

	sth_tag_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (calc_req),
		.res    (calc_res)
	);

	sth_back_mod #(
		.DEPTH (HISTORY_DEPTH),
		.AW    (AW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (mod_start),
		.ticks_back (item.ticks_back),
		.done       (mod_done),
		.back       (back)
	);

	sth_hist_mem #(
		.DEPTH (HISTORY_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (slot_q),
		.wdata ({calc_res.seconds, calc_res.fraction}),
		.re    (mem_re),
		.raddr (idx),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pending_q <= 1'b0;
			ref_q     <= '0;
			latched_q <= '0;
			slot_q    <= '0;
			wrapped_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (item.action)
							ACT_ALARM: begin
								ref_q     <= item.micro_time;
								pending_q <= 1'b1;
							end
							ACT_TICK: begin
								latched_q <= base;
								pending_q <= 1'b0;
								state_q   <= ST_TICK;
							end
							ACT_QUERY: begin
								state_q <= ST_MOD;
							end
							default: begin
							end
						endcase
					end
				end
				ST_TICK: begin
					if (calc_res.valid) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
						if (slot_q == LAST_SLOT) begin
							slot_q    <= '0;
							wrapped_q <= 1'b1;
						end else begin
							slot_q <= slot_q + AW'(1);
						end
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.action == ACT_TICK) begin
			date_q <= pending_q;
		end
		if (mem_re) begin
			hit_q <= wrapped_q || (idx < slot_q);
		end
		if (mem_we) begin
			out_q.from_query   <= 1'b0;
			out_q.tag_seconds  <= calc_res.seconds;
			out_q.tag_fraction <= calc_res.fraction;
			out_q.date_latched <= date_q;
		end else if (state_q == ST_READ) begin
			out_q.from_query   <= 1'b1;
			out_q.tag_seconds  <= hit_q ? rdata[63:32] : 32'd0;
			out_q.tag_fraction <= hit_q ? rdata[31:0] : 32'd0;
			out_q.date_latched <= 1'b0;
		end
	end

	assign done   = done_q;
	assign result = out_q;

`ifndef SYNTH
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_TICK || $past(state_q) == ST_READ)
		else $error("result strobe without work in flight");

	a_calc_only_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		calc_res.valid |-> state_q == ST_TICK)
		else $error("tag pipeline output outside tick");

	a_query_no_date: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.from_query |-> !result.date_latched)
		else $error("query result flags a latched date");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= LAST_SLOT)
		else $error("write pointer beyond history depth");

	a_tick_clears_pending: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.action == ACT_TICK |=> !pending_q)
		else $error("pending date survives a tick");
`endif

endmodule

// ----- dv/tb_sample_timestamp_history_top.sv -----
// tb_sample_timestamp_history_top: directed table and random command words for the
// sample time-tag history block, checked against a tag predictor kept in this file.
// Depends on sth_pkg and sample_timestamp_history_top.
module tb_sample_timestamp_history_top;
	import sth_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH        = 512;
	localparam int RAND_WORDS   = 1750;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 20;

	logic      clk;
	logic      arst_n;
	logic      start;
	in_word_t  item;
	logic      busy;
	logic      done;
	out_word_t result;

	sample_timestamp_history_top #(.HISTORY_DEPTH(DEPTH)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	// predictor state
	logic        alarm_armed;
	logic [31:0] micro_ref;
	logic [31:0] date_secs;
	logic [63:0] tag_hist [0:DEPTH-1];
	logic [8:0]  wr_slot;

	out_word_t pending_tags [$];
	int errors, checked, cycles;
	int n_alarm, n_tick, n_query, n_ignored, n_latched;

	typedef struct packed {
		logic [1:0]  act;
		logic [31:0] micro;
		logic [31:0] rtc;
		logic [8:0]  back;
		logic        exact;
		out_word_t   want;
	} dir_row_t;

	localparam int DIR_ROWS = 22;
	dir_row_t dir_rows [0:DIR_ROWS-1] = '{
		'{ACT_QUERY, 32'd0, 32'd0, 9'd0, 1'b1, '{1'b1, 32'd0, 32'd0, 1'b0}},
		'{ACT_QUERY, 32'd0, 32'd0, 9'd511, 1'b1, '{1'b1, 32'd0, 32'd0, 1'b0}},
		'{ACT_TICK, 32'd0, 32'd0, 9'd0, 1'b1, '{1'b0, 32'd0, 32'd0, 1'b0}},
		'{ACT_TICK, 32'd1000000, 32'd0, 9'd0, 1'b1, '{1'b0, 32'd1, 32'd0, 1'b0}},
		'{ACT_TICK, 32'd1500000, 32'd0, 9'd0, 1'b1, '{1'b0, 32'd1, 32'h8000_0000, 1'b0}},
		'{ACT_QUERY, 32'd0, 32'd0, 9'd1, 1'b1, '{1'b1, 32'd1, 32'd0, 1'b0}},
		'{ACT_ALARM, 32'd0, 32'd0, 9'd0, 1'b0, '0},
		'{ACT_TICK, 32'd0, 32'd0, 9'd0, 1'b1, '{1'b0, 32'd2208988800, 32'd0, 1'b1}},
		'{ACT_TICK, 32'd0, 32'hFFFF_FFFF, 9'd0, 1'b1, '{1'b0, 32'd2208988800, 32'd0, 1'b0}},
		'{ACT_ALARM, 32'hFFFF_FFFF, 32'd0, 9'd0, 1'b0, '0},
		'{ACT_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd0, 1'b1,
			'{1'b0, 32'd2208988799, 32'd0, 1'b1}},
		// counter one behind the reference: difference wraps to all ones
		'{ACT_TICK, 32'hFFFF_FFFE, 32'd0, 9'd0, 1'b0, '0},
		'{2'd3, 32'h1234_5678, 32'h9ABC_DEF0, 9'h0AA, 1'b0, '0},
		'{ACT_QUERY, 32'd0, 32'd0, 9'd0, 1'b0, '0},
		'{ACT_ALARM, 32'd0, 32'd0, 9'd0, 1'b0, '0},
		// latched seconds land on all ones, next tick wraps the sum
		'{ACT_TICK, 32'd999999, 32'd2085978495, 9'd0, 1'b0, '0},
		'{ACT_TICK, 32'd3000000, 32'd0, 9'd0, 1'b1, '{1'b0, 32'd2, 32'd0, 1'b0}},
		'{ACT_QUERY, 32'd0, 32'd0, 9'd256, 1'b0, '0},
		'{ACT_QUERY, 32'd0, 32'd0, 9'd510, 1'b1, '{1'b1, 32'd0, 32'd0, 1'b0}},
		'{ACT_ALARM, 32'h5555_5555, 32'hAAAA_AAAA, 9'h155, 1'b0, '0},
		'{ACT_TICK, 32'hAAAA_AAAA, 32'h5555_5555, 9'h1FF, 1'b0, '0},
		'{2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'h1FF, 1'b0, '0}
	};

	function automatic logic predict_tag(input in_word_t w, output out_word_t tag_out);
		logic [31:0] diff, whole, rem, secs;
		logic [63:0] frac;
		logic [8:0]  idx;
		logic        has_tag;
		tag_out = '0;
		has_tag = 1'b0;
		case (w.action)
			ACT_ALARM: begin
				micro_ref   = w.micro_time;
				alarm_armed = 1'b1;
			end
			ACT_TICK: begin
				if (alarm_armed) begin
					alarm_armed          = 1'b0;
					date_secs            = w.rtc_seconds + EPOCH_OFFSET;
					tag_out.date_latched = 1'b1;
				end
				diff  = w.micro_time - micro_ref;
				whole = diff / 32'(MICROS_PER_SEC);
				rem   = diff % 32'(MICROS_PER_SEC);
				frac  = {rem, 32'h0} / 64'(MICROS_PER_SEC);
				secs  = date_secs + whole;
				tag_out.tag_seconds  = secs;
				tag_out.tag_fraction = frac[31:0];
				tag_hist[wr_slot]    = {secs, frac[31:0]};
				wr_slot              = wr_slot + 9'd1;
				has_tag              = 1'b1;
			end
			ACT_QUERY: begin
				idx = wr_slot - 9'd1 - w.ticks_back;
				tag_out.from_query   = 1'b1;
				tag_out.tag_seconds  = tag_hist[idx][63:32];
				tag_out.tag_fraction = tag_hist[idx][31:0];
				has_tag              = 1'b1;
			end
			default: ;
		endcase
		return has_tag;
	endfunction

	task automatic send_word(input in_word_t w, input int gap, input logic exact,
			input out_word_t want);
		out_word_t tag;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		case (w.action)
			ACT_ALARM: n_alarm++;
			ACT_TICK:  n_tick++;
			ACT_QUERY: n_query++;
			default:   n_ignored++;
		endcase
		if (predict_tag(w, tag)) begin
			if (tag.date_latched) n_latched++;
			pending_tags.push_back(exact ? want : tag);
		end
	endtask

	function automatic int pick_gap(input logic no_idle);
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic cmp_field(input string nm, input logic [31:0] e, input logic [31:0] a);
		if (e !== a) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, nm, e, a);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_tags.size() == 0) begin
				$display("%0t ns: unexpected result word %h", $time, result);
				errors++;
			end else begin
				out_word_t want;
				want = pending_tags.pop_front();
				cmp_field("from_query", 32'(want.from_query), 32'(result.from_query));
				cmp_field("tag_seconds", want.tag_seconds, result.tag_seconds);
				cmp_field("tag_fraction", want.tag_fraction, result.tag_fraction);
				cmp_field("date_latched", 32'(want.date_latched), 32'(result.date_latched));
				checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected", cycles,
				pending_tags.size());
			$display("tb_sample_timestamp_history_top: FAIL");
			$finish;
		end
	end

	initial begin
		in_word_t    w;
		logic [31:0] sim_us;
		logic [31:0] rtc_base;
		logic        no_idle;
		int          r;
		errors = 0; checked = 0; cycles = 0;
		n_alarm = 0; n_tick = 0; n_query = 0; n_ignored = 0; n_latched = 0;
		alarm_armed = 1'b0;
		micro_ref   = '0;
		date_secs   = '0;
		wr_slot     = '0;
		for (int i = 0; i < DEPTH; i++) tag_hist[i] = '0;
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		no_idle = 1'b0;
		for (int i = 0; i < DIR_ROWS; i++) begin
			w.action      = dir_rows[i].act;
			w.micro_time  = dir_rows[i].micro;
			w.rtc_seconds = dir_rows[i].rtc;
			w.ticks_back  = dir_rows[i].back;
			send_word(w, pick_gap(no_idle), dir_rows[i].exact, dir_rows[i].want);
		end

		sim_us   = $urandom();
		rtc_base = $urandom();
		for (int i = 0; i < RAND_WORDS; i++) begin
			if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 3) sim_us = 32'hFFFF_FFFF - $urandom_range(0, 20000);
			else if (r < 8) sim_us = $urandom();
			else sim_us = sim_us + $urandom_range(1, 5000);
			w.micro_time = ($urandom_range(0, 9) == 0) ? $urandom() : sim_us;
			w.rtc_seconds = ($urandom_range(0, 4) == 0) ? $urandom()
				: rtc_base + sim_us / 32'd1000000;
			r = $urandom_range(0, 99);
			if (r < 40) w.ticks_back = 9'($urandom_range(0, 15));
			else if (r < 55) w.ticks_back = 9'd511 - 9'($urandom_range(0, 3));
			else w.ticks_back = 9'($urandom());
			r = $urandom_range(0, 99);
			if (r < 12) w.action = ACT_ALARM;
			else if (r < 62) w.action = ACT_TICK;
			else if (r < 95) w.action = ACT_QUERY;
			else w.action = 2'd3;
			send_word(w, pick_gap(no_idle), 1'b0, '0);
		end
		start <= 1'b0;

		while (pending_tags.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d alarms, %0d ticks (%0d with a date latched), %0d queries,",
			n_alarm, n_tick, n_latched, n_query);
		$display("%0d ignored words; %0d result words checked, %0d mismatches",
			n_ignored, checked, errors);
		if (errors == 0 && pending_tags.size() == 0) begin
			$display("tb_sample_timestamp_history_top: PASS");
		end else begin
			$display("tb_sample_timestamp_history_top: FAIL");
		end
		$finish;
	end

endmodule
